>>> design/gym_command_stream_parser_unit_defines.svh
// Assertion macros for the command stream parser.
// The enclosing module must provide clock and reset signals of those names.
`ifndef GYM_COMMAND_STREAM_PARSER_UNIT_DEFINES_SVH
`define GYM_COMMAND_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GCSP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcsp assertion failed");
`define GCSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gcsp assertion failed");
`else
`define GCSP_ASSERT_SAME(label, ante, cons)
`define GCSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/gcsp_pkg.sv
package gcsp_pkg;

   localparam int P_W           = 11;
   localparam int DAC_DEPTH_DEF = 63;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [15:0] SAMPLE_RATE_RESET = 16'd44100;
   localparam logic        REG_SAMPLE_RATE   = 1'b0;

   // sample_rate / 30 as a reciprocal multiply, exact for all 16-bit rates
   localparam logic [16:0]  RECIP_30    = 17'd34953;
   localparam int           RECIP_SHIFT = 20;
   localparam logic [P_W-1:0] P_MAX     = 11'd2047;

   localparam logic [7:0] OPC_WAIT = 8'h00;
   localparam logic [7:0] OPC_FM0  = 8'h01;
   localparam logic [7:0] OPC_FM1  = 8'h02;
   localparam logic [7:0] OPC_PSG  = 8'h03;
   localparam logic [7:0] DAC_ADDR = 8'h2a;

   localparam logic [2:0] PH_OPCODE   = 3'd0;
   localparam logic [2:0] PH_B0_ADDR  = 3'd1;
   localparam logic [2:0] PH_B0_DATA  = 3'd2;
   localparam logic [2:0] PH_B1_ADDR  = 3'd3;
   localparam logic [2:0] PH_B1_DATA  = 3'd4;
   localparam logic [2:0] PH_PSG_DATA = 3'd5;

   localparam logic [2:0] KIND_FM0   = 3'd0;
   localparam logic [2:0] KIND_FM1   = 3'd1;
   localparam logic [2:0] KIND_PSG   = 3'd2;
   localparam logic [2:0] KIND_DAC   = 3'd3;
   localparam logic [2:0] KIND_FRAME = 3'd4;

   localparam logic [31:0] MS_SHORT = 32'd33;
   localparam logic [31:0] MS_LONG  = 32'd34;
   localparam logic [1:0]  MS_LONG_PHASE = 2'd2;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic emit_dac;
      logic emit_frame;
   } gcsp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic closes_frame;
      logic dac_empty;
      logic div_done;
      logic span_last;
   } gcsp_stat_type;

endpackage

>>> design/gcsp_chan_if.sv
interface gcsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface gcsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  reg_addr;
   logic [7:0]  reg_data;
   logic [10:0] sample_offset;
   logic [10:0] sample_count;
   logic [31:0] time_ms;
   logic        last;

   modport source (output valid, output kind, output reg_addr, output reg_data,
                   output sample_offset, output sample_count, output time_ms,
                   output last, input ready);
   modport sink   (input valid, input kind, input reg_addr, input reg_data,
                   input sample_offset, input sample_count, input time_ms,
                   input last, output ready);
endinterface

>>> design/gcsp_div.sv
module gcsp_div
   import gcsp_pkg::*;
#(
   parameter int DIV_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [P_W-1:0]   dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [P_W-1:0]   quot,
   output logic [DIV_W-1:0] rem,
   output logic             done
);

   localparam int CNT_W = $clog2(P_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [P_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, dvd_ff[P_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // one restoring step per cycle, quotient bits shift in from the right
         dvd_in = {dvd_ff[P_W-2:0], fits};
         rem_in = fits ? DIV_W'(trial - {1'b0, dsr_ff}) : trial[DIV_W-1:0];
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(P_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quot = dvd_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

>>> design/gcsp_ctrl.sv
module gcsp_ctrl
   import gcsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  gcsp_stat_type stat,
   output gcsp_cmd_type  cmd,
   output logic          req_ready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_DAC   = 4'b0100,
      ST_FRAME = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_ready && stat.req_valid;
            if (cmd.accept && stat.closes_frame) begin
               if (stat.dac_empty) begin
                  state_in = ST_FRAME;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_DAC;
         end
         ST_DAC: begin
            if (stat.out_free) begin
               cmd.emit_dac = 1'b1;
               if (stat.span_last) state_in = ST_FRAME;
            end
         end
         ST_FRAME: begin
            if (stat.out_free) begin
               cmd.emit_frame = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/gcsp_dpath.sv
module gcsp_dpath
   import gcsp_pkg::*;
#(
   parameter int DAC_DEPTH = DAC_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gcsp_cmd_type          cmd,
   output gcsp_stat_type         stat,
   input  logic                  req_valid,
   input  logic [7:0]            req_byte,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_kind,
   output logic [7:0]            rsp_addr,
   output logic [7:0]            rsp_data,
   output logic [P_W-1:0]        rsp_offset,
   output logic [P_W-1:0]        rsp_count,
   output logic [31:0]           rsp_time,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata,
   output logic [15:0]           sample_rate
);

   localparam int CNT_W = $clog2(DAC_DEPTH + 1);
   localparam int IDX_W = (DAC_DEPTH > 1) ? $clog2(DAC_DEPTH) : 1;

   logic [15:0]    rate_ff, rate_in;
   logic [32:0]    rate_prod;
   logic [12:0]    rate_quot;
   logic [P_W-1:0] period;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       held_ff, held_in;
   logic             half_ff, half_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      clk_ms_ff, clk_ms_in;
   logic [1:0]       ms_ph_ff, ms_ph_in;

   logic [7:0]       dac_mem [DAC_DEPTH];
   logic             mem_we;
   logic [7:0]       rd_data_ff;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;

   logic [P_W-1:0]   q_acc_ff, q_acc_in;
   logic [CNT_W-1:0] r_acc_ff, r_acc_in;
   logic [P_W-1:0]   q_step;
   logic [CNT_W-1:0] r_step;
   logic [CNT_W:0]   r_sum;
   logic             r_wrap;
   logic [P_W-1:0]   q_next;
   logic [CNT_W-1:0] r_next;
   logic             div_done;

   logic             out_v_ff, out_v_in;
   logic [2:0]       kind_ff, kind_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       data_ff, data_in;
   logic [P_W-1:0]   off_ff, off_in;
   logic [P_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]      time_ff, time_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic             opc_phase;

   assign rate_in   = csr_we ? csr_wdata : rate_ff;
   assign rate_prod = rate_ff * RECIP_30;
   assign rate_quot = rate_prod[32:RECIP_SHIFT];
   assign period    = (rate_quot > {2'b00, P_MAX}) ? P_MAX : rate_quot[P_W-1:0];

   assign out_free = !out_v_ff || rsp_ready;

   always_comb begin
      unique case (phase_ff) inside
         PH_B0_ADDR, PH_B0_DATA, PH_B1_ADDR, PH_B1_DATA, PH_PSG_DATA: opc_phase = 1'b0;
         default: opc_phase = 1'b1;
      endcase
   end

   gcsp_div #(
      .DIV_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (period),
      .divisor  (count_ff),
      .quot     (q_step),
      .rem      (r_step),
      .done     (div_done)
   );

   // next span boundary: floor((k+1)*P/n) from floor(k*P/n) and its remainder
   assign r_sum  = {1'b0, r_acc_ff} + {1'b0, r_step};
   assign r_wrap = r_sum >= {1'b0, count_ff};
   assign r_next = r_wrap ? CNT_W'(r_sum - {1'b0, count_ff}) : r_sum[CNT_W-1:0];
   assign q_next = P_W'(q_acc_ff + q_step + {{(P_W-1){1'b0}}, r_wrap});

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      half_in   = half_ff;
      count_in  = count_ff;
      clk_ms_in = clk_ms_ff;
      ms_ph_in  = ms_ph_ff;
      mem_we    = 1'b0;
      rd_idx_in = rd_idx_ff;
      q_acc_in  = q_acc_ff;
      r_acc_in  = r_acc_ff;

      out_v_in = out_v_ff && !rsp_ready;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      time_in  = time_ff;
      last_in  = last_ff;

      if (cmd.accept) begin
         rd_idx_in = '0;
         q_acc_in  = '0;
         r_acc_in  = '0;
         // writes share one output shape, only kind and address change below
         addr_in   = held_ff;
         data_in   = req_byte;
         off_in    = '0;
         cnt_in    = '0;
         time_in   = '0;
         last_in   = 1'b1;
         phase_in  = PH_OPCODE;
         case (phase_ff)
            PH_B0_ADDR: begin
               held_in  = req_byte;
               phase_in = PH_B0_DATA;
            end
            PH_B0_DATA: begin
               if (held_ff == DAC_ADDR) begin
                  // drop the sample once the buffer or the period is full
                  if (count_ff < CNT_W'(DAC_DEPTH) &&
                      {{(P_W-CNT_W){1'b0}}, count_ff} < period) begin
                     mem_we   = 1'b1;
                     count_in = CNT_W'(count_ff + 1'b1);
                  end
               end else begin
                  out_v_in = 1'b1;
                  kind_in  = KIND_FM0;
               end
            end
            PH_B1_ADDR: begin
               held_in  = req_byte;
               phase_in = PH_B1_DATA;
            end
            PH_B1_DATA: begin
               out_v_in = 1'b1;
               kind_in  = KIND_FM1;
            end
            PH_PSG_DATA: begin
               out_v_in = 1'b1;
               kind_in  = KIND_PSG;
               addr_in  = '0;
            end
            default: begin
               case (req_byte)
                  OPC_FM0:  phase_in = PH_B0_ADDR;
                  OPC_FM1:  phase_in = PH_B1_ADDR;
                  OPC_PSG:  phase_in = PH_PSG_DATA;
                  OPC_WAIT: half_in  = !half_ff;
                  default:  ;
               endcase
            end
         endcase
      end

      if (cmd.emit_dac) begin
         out_v_in  = 1'b1;
         kind_in   = KIND_DAC;
         addr_in   = '0;
         data_in   = rd_data_ff;
         off_in    = q_acc_ff;
         cnt_in    = P_W'(q_next - q_acc_ff);
         time_in   = '0;
         last_in   = 1'b0;
         q_acc_in  = q_next;
         r_acc_in  = r_next;
         rd_idx_in = CNT_W'(rd_idx_ff + 1'b1);
      end

      if (cmd.emit_frame) begin
         if (ms_ph_ff >= MS_LONG_PHASE) begin
            clk_ms_in = clk_ms_ff + MS_LONG;
            ms_ph_in  = '0;
         end else begin
            clk_ms_in = clk_ms_ff + MS_SHORT;
            ms_ph_in  = 2'(ms_ph_ff + 1'b1);
         end
         count_in = '0;
         out_v_in = 1'b1;
         kind_in  = KIND_FRAME;
         addr_in  = '0;
         data_in  = '0;
         off_in   = '0;
         cnt_in   = period;
         time_in  = clk_ms_in;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) dac_mem[count_ff[IDX_W-1:0]] <= req_byte;
   end

   // read port follows the next index so data is ready when the span goes out
   always_ff @(posedge clock) begin
      if (rd_idx_in < CNT_W'(DAC_DEPTH)) rd_data_ff <= dac_mem[rd_idx_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= SAMPLE_RATE_RESET;
         phase_ff  <= PH_OPCODE;
         held_ff   <= '0;
         half_ff   <= 1'b0;
         count_ff  <= '0;
         clk_ms_ff <= '0;
         ms_ph_ff  <= '0;
         rd_idx_ff <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         rate_ff   <= rate_in;
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         half_ff   <= half_in;
         count_ff  <= count_in;
         clk_ms_ff <= clk_ms_in;
         ms_ph_ff  <= ms_ph_in;
         rd_idx_ff <= rd_idx_in;
         out_v_ff  <= out_v_in;
      end
      q_acc_ff <= q_acc_in;
      r_acc_ff <= r_acc_in;
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      off_ff   <= off_in;
      cnt_ff   <= cnt_in;
      time_ff  <= time_in;
      last_ff  <= last_in;
   end

   assign stat.req_valid    = req_valid;
   assign stat.out_free     = out_free;
   assign stat.closes_frame = opc_phase && (req_byte == OPC_WAIT) && half_ff;
   assign stat.dac_empty    = (count_ff == '0);
   assign stat.div_done     = div_done;
   assign stat.span_last    = ({1'b0, rd_idx_ff} + 1'b1) == {1'b0, count_ff};

   assign rsp_valid   = out_v_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_addr    = addr_ff;
   assign rsp_data    = data_ff;
   assign rsp_offset  = off_ff;
   assign rsp_count   = cnt_ff;
   assign rsp_time    = time_ff;
   assign rsp_last    = last_ff;
   assign sample_rate = rate_ff;

endmodule

>>> design/gym_command_stream_parser_unit.sv
// Channel    Dir   Handshake          Payload
// req_chan   in    valid/ready        stream_byte
// rsp_chan   out   valid/ready        kind, reg_addr, reg_data, sample_offset,
//                                     sample_count, time_ms, last
// csr_*      in    APB, pready = 1    sample_rate at byte address 0
//
// Command and operand bytes are taken while the parser is idle and the output is
// free; a write result is registered at the edge that takes its byte. A closing wait
// byte with n buffered DAC samples passes acceptance, the restoring divider on P / n,
// one result per DAC span, then the frame result; with none buffered, the frame result.
// Reset is synchronous and active high; it needs no clearing pass. A stalled
// result holds the output register; input is taken only while it is empty or emptying.
`include "gym_command_stream_parser_unit_defines.svh"

module gym_command_stream_parser_unit
   import gcsp_pkg::*;
#(
   parameter int DAC_DEPTH = DAC_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gcsp_req_if.sink              req_chan,
   gcsp_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   gcsp_cmd_type  cmd;
   gcsp_stat_type stat;
   logic          csr_sel;
   logic          csr_we;
   logic [15:0]   sample_rate;

   assign csr_pready = 1'b1;
   assign csr_sel    = (csr_paddr[2] == REG_SAMPLE_RATE);
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel;
   assign csr_prdata = csr_sel ? {{(CSR_DATA_W-16){1'b0}}, sample_rate} : '0;

   gcsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_chan.ready)
   );

   gcsp_dpath #(
      .DAC_DEPTH (DAC_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_valid   (req_chan.valid),
      .req_byte    (req_chan.stream_byte),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_kind    (rsp_chan.kind),
      .rsp_addr    (rsp_chan.reg_addr),
      .rsp_data    (rsp_chan.reg_data),
      .rsp_offset  (rsp_chan.sample_offset),
      .rsp_count   (rsp_chan.sample_count),
      .rsp_time    (rsp_chan.time_ms),
      .rsp_last    (rsp_chan.last),
      .csr_we      (csr_we),
      .csr_wdata   (csr_pwdata[15:0]),
      .sample_rate (sample_rate)
   );

   `GCSP_ASSERT_NEXT(a_busy_blocks_input, cmd.div_start, !req_chan.ready)
   `GCSP_ASSERT_SAME(a_div_done_while_busy, stat.div_done, !req_chan.ready)
   `GCSP_ASSERT_SAME(a_emit_needs_room, cmd.emit_dac || cmd.emit_frame, stat.out_free)
   `GCSP_ASSERT_SAME(a_dac_not_last, rsp_chan.valid && rsp_chan.kind == KIND_DAC, !rsp_chan.last)

endmodule
